// ===== rtl/core/hps_pkg.sv =====
// ----------------------------------------------------------------------------
// hps_pkg
// shared types and constants of the haptic pattern sequencer
// ----------------------------------------------------------------------------
package hps_pkg;

  // width of a pwm duty
  localparam int unsigned DUTY_BITS = 10;

  // width of a millisecond count and of the configuration port
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_WEAK     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MEDIUM   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_STRONG   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_ON     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_GAP    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ON      = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_OFF     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_DEFAULT = 8'd7;

  // register reset values
  localparam int unsigned DUTY_WEAK_RST     = 360;
  localparam int unsigned DUTY_MEDIUM_RST   = 640;
  localparam int unsigned DUTY_STRONG_RST   = 900;
  localparam logic [MS_W-1:0] NOTIFY_ON_RST     = 16'd90;
  localparam logic [MS_W-1:0] NOTIFY_GAP_RST    = 16'd60;
  localparam logic [MS_W-1:0] ALARM_ON_RST      = 16'd650;
  localparam logic [MS_W-1:0] ALARM_OFF_RST     = 16'd350;
  localparam logic [MS_W-1:0] PULSE_DEFAULT_RST = 16'd180;

  // item kind
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // strength codes
  localparam logic [1:0] STR_WEAK   = 2'd0;
  localparam logic [1:0] STR_MEDIUM = 2'd1;
  localparam logic [1:0] STR_STRONG = 2'd2;

  // phase codes within a pattern
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef enum logic [1:0] {
    PAT_PULSE  = 2'd0,
    PAT_NOTIFY = 2'd1,
    PAT_ALARM  = 2'd2,
    PAT_STOP   = 2'd3
  } pattern_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PULSE  = 2'd1,
    MODE_NOTIFY = 2'd2,
    MODE_ALARM  = 2'd3
  } run_mode_e;

  // phase lengths from the configuration registers
  typedef struct packed {
    logic [MS_W-1:0] notify_on;
    logic [MS_W-1:0] notify_gap;
    logic [MS_W-1:0] alarm_on;
    logic [MS_W-1:0] alarm_off;
    logic [MS_W-1:0] pulse_default;
  } hps_times_t;

endpackage

// ===== rtl/core/haptic_pattern_sequencer_top.sv =====
// result: registered on each input transfer
// throughput: one item per cycle while the result side does not stall; the only limit is the single result register,
//   which is refilled in the same cycle it is drained
// reset: asynchronous, active low; pattern idle, motor off, held strength medium,
//   configuration registers at their default duties and phase lengths
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer_top
// vibration motor pattern sequencer driving a pwm duty per command or tick
// ----------------------------------------------------------------------------
module haptic_pattern_sequencer_top
  import hps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [1:0]           pattern_i,
  input  logic [1:0]           strength_i,
  input  logic [MS_W-1:0]      pulse_ms_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DUTY_BITS-1:0] duty_o,
  output logic                 active_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  logic [DUTY_BITS-1:0] duty_weak, duty_medium, duty_strong;
  hps_times_t           times;
  logic                 in_xfer;
  logic [DUTY_BITS-1:0] res_duty;
  logic                 res_active;

  logic                 out_valid_q, out_valid_d;
  logic [DUTY_BITS-1:0] duty_q;
  logic                 active_q;

  // register writes are always taken; they should only arrive while the block is idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  hps_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (cfg_valid_i),
    .wr_idx_i      (cfg_index_i),
    .wr_data_i     (cfg_data_i),
    .duty_weak_o   (duty_weak),
    .duty_medium_o (duty_medium),
    .duty_strong_o (duty_strong),
    .times_o       (times)
  );

  // an input transfer is possible whenever the result register is empty or
  // is being drained in this same cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // state update and duty select for the item in flight
  hps_seq_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_xfer),
    .op_i          (op_i),
    .pattern_i     (pattern_i),
    .strength_i    (strength_i),
    .pulse_ms_i    (pulse_ms_i),
    .duty_weak_i   (duty_weak),
    .duty_medium_i (duty_medium),
    .duty_strong_i (duty_strong),
    .times_i       (times),
    .duty_o        (res_duty),
    .active_o      (res_active)
  );

  // result register: filled on each input transfer, emptied on output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      duty_q   <= res_duty;
      active_q <= res_active;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign active_o    = active_q;

`ifndef NO_ASSERTIONS
  // an idle pattern never drives the motor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !active_o) |-> (duty_o == '0))
    else $error("duty nonzero while no pattern is running");

  // a stop command yields an idle result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op_i == OP_CMD && pattern_e'(pattern_i) == PAT_STOP)
      |=> (out_valid_o && !active_o && duty_o == '0))
    else $error("stop command did not idle the sequencer");

  // any other command starts a running pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op_i == OP_CMD && pattern_e'(pattern_i) != PAT_STOP)
      |=> (out_valid_o && active_o))
    else $error("command did not start a pattern");
`endif

endmodule

// ===== rtl/core/hps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hps_cfg_regs
// configuration register file: duty levels and phase lengths
// ----------------------------------------------------------------------------
module hps_cfg_regs
  import hps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CFG_IDX_W-1:0] wr_idx_i,
  input  logic [CFG_DAT_W-1:0] wr_data_i,
  output logic [DUTY_BITS-1:0] duty_weak_o,
  output logic [DUTY_BITS-1:0] duty_medium_o,
  output logic [DUTY_BITS-1:0] duty_strong_o,
  output hps_times_t           times_o
);

  logic [DUTY_BITS-1:0] duty_weak_q, duty_medium_q, duty_strong_q;
  hps_times_t           times_q;
  logic [DUTY_BITS-1:0] wr_duty;

  assign wr_duty = DUTY_BITS'(wr_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_weak_q           <= DUTY_BITS'(DUTY_WEAK_RST);
      duty_medium_q         <= DUTY_BITS'(DUTY_MEDIUM_RST);
      duty_strong_q         <= DUTY_BITS'(DUTY_STRONG_RST);
      times_q.notify_on     <= NOTIFY_ON_RST;
      times_q.notify_gap    <= NOTIFY_GAP_RST;
      times_q.alarm_on      <= ALARM_ON_RST;
      times_q.alarm_off     <= ALARM_OFF_RST;
      times_q.pulse_default <= PULSE_DEFAULT_RST;
    end else if (wr_en_i) begin
      // indexes past the last register are dropped
      if (wr_idx_i == REG_DUTY_WEAK)     duty_weak_q           <= wr_duty;
      if (wr_idx_i == REG_DUTY_MEDIUM)   duty_medium_q         <= wr_duty;
      if (wr_idx_i == REG_DUTY_STRONG)   duty_strong_q         <= wr_duty;
      if (wr_idx_i == REG_NOTIFY_ON)     times_q.notify_on     <= MS_W'(wr_data_i);
      if (wr_idx_i == REG_NOTIFY_GAP)    times_q.notify_gap    <= MS_W'(wr_data_i);
      if (wr_idx_i == REG_ALARM_ON)      times_q.alarm_on      <= MS_W'(wr_data_i);
      if (wr_idx_i == REG_ALARM_OFF)     times_q.alarm_off     <= MS_W'(wr_data_i);
      if (wr_idx_i == REG_PULSE_DEFAULT) times_q.pulse_default <= MS_W'(wr_data_i);
    end
  end

  assign duty_weak_o   = duty_weak_q;
  assign duty_medium_o = duty_medium_q;
  assign duty_strong_o = duty_strong_q;
  assign times_o       = times_q;

endmodule

// ===== rtl/core/hps_seq_core.sv =====
// ----------------------------------------------------------------------------
// hps_seq_core
// pattern state and its combinational update for one command or tick
// ----------------------------------------------------------------------------
module hps_seq_core
  import hps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 op_i,
  input  logic [1:0]           pattern_i,
  input  logic [1:0]           strength_i,
  input  logic [MS_W-1:0]      pulse_ms_i,
  input  logic [DUTY_BITS-1:0] duty_weak_i,
  input  logic [DUTY_BITS-1:0] duty_medium_i,
  input  logic [DUTY_BITS-1:0] duty_strong_i,
  input  hps_times_t           times_i,
  output logic [DUTY_BITS-1:0] duty_o,
  output logic                 active_o
);

  run_mode_e       mode_q, mode_d;
  logic [1:0]      phase_q, phase_d;
  logic [MS_W-1:0] ms_left_q, ms_left_d;
  logic [1:0]      held_q, held_d;
  logic            motor_q, motor_d;

  // next state
  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    ms_left_d = ms_left_q;
    held_d    = held_q;
    motor_d   = motor_q;
    if (op_i == OP_TICK) begin
      if (mode_q != MODE_IDLE && ms_left_q > MS_W'(1)) begin
        ms_left_d = ms_left_q - MS_W'(1);
      end else begin
        unique case (mode_q)
          MODE_IDLE: ;
          MODE_PULSE: begin
            mode_d    = MODE_IDLE;
            phase_d   = PH_FIRST;
            ms_left_d = '0;
            motor_d   = 1'b0;
          end
          MODE_NOTIFY: begin
            priority if (phase_q == PH_FIRST) begin
              phase_d   = PH_SECOND;
              motor_d   = 1'b0;
              ms_left_d = times_i.notify_gap;
            end else if (phase_q == PH_SECOND) begin
              phase_d   = PH_THIRD;
              motor_d   = 1'b1;
              ms_left_d = times_i.notify_on;
            end else begin
              mode_d    = MODE_IDLE;
              phase_d   = PH_FIRST;
              ms_left_d = '0;
              motor_d   = 1'b0;
            end
          end
          MODE_ALARM: begin
            if (phase_q == PH_FIRST) begin
              phase_d   = PH_SECOND;
              motor_d   = 1'b0;
              ms_left_d = times_i.alarm_off;
            end else begin
              phase_d   = PH_FIRST;
              motor_d   = 1'b1;
              ms_left_d = times_i.alarm_on;
            end
          end
          default: ;
        endcase
      end
    end else begin
      phase_d = PH_FIRST;
      if (pattern_e'(pattern_i) == PAT_STOP) begin
        mode_d    = MODE_IDLE;
        ms_left_d = '0;
        motor_d   = 1'b0;
      end else begin
        held_d  = (strength_i > STR_STRONG) ? STR_MEDIUM : strength_i;
        motor_d = 1'b1;
      end
      unique case (pattern_e'(pattern_i))
        PAT_PULSE: begin
          mode_d    = MODE_PULSE;
          ms_left_d = (pulse_ms_i != '0) ? pulse_ms_i : times_i.pulse_default;
        end
        PAT_NOTIFY: begin
          mode_d    = MODE_NOTIFY;
          ms_left_d = times_i.notify_on;
        end
        PAT_ALARM: begin
          mode_d    = MODE_ALARM;
          ms_left_d = times_i.alarm_on;
        end
        PAT_STOP: ;
        default: ;
      endcase
    end
  end

  // result from the updated state and the live duty registers
  always_comb begin
    duty_o = '0;
    if (motor_d) begin
      unique case (held_d)
        STR_WEAK:   duty_o = duty_weak_i;
        STR_STRONG: duty_o = duty_strong_i;
        default:    duty_o = duty_medium_i;
      endcase
    end
    active_o = (mode_d != MODE_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      phase_q   <= PH_FIRST;
      ms_left_q <= '0;
      held_q    <= STR_MEDIUM;
      motor_q   <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      ms_left_q <= ms_left_d;
      held_q    <= held_d;
      motor_q   <= motor_d;
    end
  end

endmodule

// ===== dv/hps_checker.sv =====
// ----------------------------------------------------------------------------
// hps_checker
// follows every transfer on the sequencer's channels, keeps its own copy of
// the pattern state and registers, and compares each result with the duty
// and activity it should carry
// ----------------------------------------------------------------------------
module hps_checker
  import hps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 op_i,
  input  logic [1:0]           pattern_i,
  input  logic [1:0]           strength_i,
  input  logic [MS_W-1:0]      pulse_ms_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [DUTY_BITS-1:0] duty_i,
  input  logic                 active_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 drained_o,
  output int unsigned          fail_count_o
);

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic                 active;
  } motor_drive_t;

  motor_drive_t drive_q[$];

  logic [DUTY_BITS-1:0] duty_weak_r;
  logic [DUTY_BITS-1:0] duty_medium_r;
  logic [DUTY_BITS-1:0] duty_strong_r;
  hps_times_t      times_r;

  run_mode_e       mode_r;
  logic [1:0]      phase_r;
  logic [MS_W-1:0] ms_left_r;
  logic [1:0]      strength_r;
  logic            motor_on_r;

  int unsigned     mismatches;

  assign fail_count_o = mismatches;

  function automatic logic [DUTY_BITS-1:0] strength_duty(logic [1:0] s);
    if (s == STR_WEAK) return duty_weak_r;
    if (s == STR_STRONG) return duty_strong_r;
    return duty_medium_r;
  endfunction

  task automatic load_phase(logic [1:0] ph, logic on, logic [MS_W-1:0] ms);
    phase_r    = ph;
    motor_on_r = on;
    ms_left_r  = ms;
  endtask

  task automatic stop_motor();
    mode_r     = MODE_IDLE;
    phase_r    = PH_FIRST;
    ms_left_r  = '0;
    motor_on_r = 1'b0;
  endtask

  // a phase holding zero or one ends on this tick
  task automatic count_tick();
    if (mode_r != MODE_IDLE) begin
      if (ms_left_r > MS_W'(1)) begin
        ms_left_r = ms_left_r - MS_W'(1);
      end else begin
        case (mode_r)
          MODE_PULSE: begin
            stop_motor();
          end
          MODE_NOTIFY: begin
            if (phase_r == PH_FIRST) load_phase(PH_SECOND, 1'b0, times_r.notify_gap);
            else if (phase_r == PH_SECOND) load_phase(PH_THIRD, 1'b1, times_r.notify_on);
            else stop_motor();
          end
          default: begin
            if (phase_r == PH_FIRST) load_phase(PH_SECOND, 1'b0, times_r.alarm_off);
            else load_phase(PH_FIRST, 1'b1, times_r.alarm_on);
          end
        endcase
      end
    end
  endtask

  task automatic start_command(pattern_e pat, logic [1:0] str, logic [MS_W-1:0] dur);
    if (pat == PAT_STOP) begin
      stop_motor();
    end else begin
      strength_r = (str > STR_STRONG) ? STR_MEDIUM : str;
      case (pat)
        PAT_PULSE: begin
          mode_r = MODE_PULSE;
          load_phase(PH_FIRST, 1'b1, (dur != '0) ? dur : times_r.pulse_default);
        end
        PAT_NOTIFY: begin
          mode_r = MODE_NOTIFY;
          load_phase(PH_FIRST, 1'b1, times_r.notify_on);
        end
        default: begin
          mode_r = MODE_ALARM;
          load_phase(PH_FIRST, 1'b1, times_r.alarm_on);
        end
      endcase
    end
  endtask

  task automatic apply_item();
    motor_drive_t next;
    if (op_i == OP_TICK) count_tick();
    else start_command(pattern_e'(pattern_i), strength_i, pulse_ms_i);
    next.duty   = motor_on_r ? strength_duty(strength_r) : '0;
    next.active = (mode_r != MODE_IDLE);
    drive_q.push_back(next);
  endtask

  task automatic check_result();
    motor_drive_t want;
    if (drive_q.size() == 0) begin
      $error("result with no expectation waiting: duty %0d active %0d", duty_i, active_i);
      mismatches++;
    end else begin
      want = drive_q.pop_front();
      if (duty_i !== want.duty) begin
        $error("duty mismatch: expected %0d, actual %0d", want.duty, duty_i);
        mismatches++;
      end
      if (active_i !== want.active) begin
        $error("active mismatch: expected %0d, actual %0d", want.active, active_i);
        mismatches++;
      end
    end
  endtask

  // unknown indexes fall through and change nothing
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_DUTY_WEAK:     duty_weak_r           = DUTY_BITS'(data);
      REG_DUTY_MEDIUM:   duty_medium_r         = DUTY_BITS'(data);
      REG_DUTY_STRONG:   duty_strong_r         = DUTY_BITS'(data);
      REG_NOTIFY_ON:     times_r.notify_on     = data;
      REG_NOTIFY_GAP:    times_r.notify_gap    = data;
      REG_ALARM_ON:      times_r.alarm_on      = data;
      REG_ALARM_OFF:     times_r.alarm_off     = data;
      REG_PULSE_DEFAULT: times_r.pulse_default = data;
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_weak_r           = DUTY_BITS'(DUTY_WEAK_RST);
      duty_medium_r         = DUTY_BITS'(DUTY_MEDIUM_RST);
      duty_strong_r         = DUTY_BITS'(DUTY_STRONG_RST);
      times_r.notify_on     = NOTIFY_ON_RST;
      times_r.notify_gap    = NOTIFY_GAP_RST;
      times_r.alarm_on      = ALARM_ON_RST;
      times_r.alarm_off     = ALARM_OFF_RST;
      times_r.pulse_default = PULSE_DEFAULT_RST;
      strength_r            = STR_MEDIUM;
      stop_motor();
      drive_q.delete();
      mismatches            = 0;
      drained_o            <= 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      // results are registered behind their item, so compare before queuing
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) apply_item();
      drained_o <= (drive_q.size() == 0);
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives directed and random command and tick items into the haptic pattern
// sequencer across several register settings, with bursty input and a
// stalling result side; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
module tb;
  import hps_pkg::*;

  // strength code outside the named range, folded to medium by the block
  localparam logic [1:0]  STR_FOLDED = 2'd3;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 150;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // item channel
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 op = OP_TICK;
  logic [1:0]           pattern = '0;
  logic [1:0]           strength = '0;
  logic [MS_W-1:0]      pulse_ms = '0;

  // result channel
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DUTY_BITS-1:0] duty;
  logic                 active;

  // configuration channel
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // checker status
  logic                 drained;
  int unsigned          fail_count;

  // sender burst bookkeeping
  int unsigned          burst_left = 0;
  int unsigned          items_sent = 0;

  // receiver stall pattern, rotated each cycle and swapped out now and then
  logic [15:0]          ready_pattern = 16'hFFFF;
  int unsigned          pattern_age = 0;

  always #10 clk = ~clk;

  haptic_pattern_sequencer_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (op),
    .pattern_i     (pattern),
    .strength_i    (strength),
    .pulse_ms_i    (pulse_ms),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .duty_o        (duty),
    .active_o      (active),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  hps_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .op_i          (op),
    .pattern_i     (pattern),
    .strength_i    (strength),
    .pulse_ms_i    (pulse_ms),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .duty_i        (duty),
    .active_i      (active),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .drained_o     (drained),
    .fail_count_o  (fail_count)
  );

  // result side: all-ready stretches, random stalls, dense stalls and sparse stalls
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(3))
        0: ready_pattern <= 16'hFFFF;
        1: ready_pattern <= 16'($urandom);
        2: ready_pattern <= 16'($urandom) & 16'($urandom);
        default: ready_pattern <= 16'($urandom) | 16'($urandom);
      endcase
      pattern_age <= 16 * $urandom_range(1, 8);
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_age <= pattern_age - 1;
    end
    out_ready <= ready_pattern[0];
  end

  // one item transfer; a fresh burst may open with an idle gap
  task automatic send_item(input logic op_v, input logic [1:0] pat_v,
                           input logic [1:0] str_v, input logic [MS_W-1:0] dur_v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
    end
    in_valid    <= 1'b1;
    op          <= op_v;
    pattern     <= pat_v;
    strength    <= str_v;
    pulse_ms    <= dur_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // tick with junk in the fields the block should ignore
  task automatic send_tick();
    send_item(OP_TICK, 2'($urandom), 2'($urandom), 16'($urandom));
  endtask

  // mostly short pulses so they end within the following ticks
  function automatic logic [MS_W-1:0] pulse_length();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 2) return '0;
    if (pick < 8) return MS_W'($urandom_range(1, 6));
    if (pick == 8) return '1;
    return MS_W'($urandom);
  endfunction

  // phase lengths short enough for patterns to cycle through
  function automatic logic [CFG_DAT_W-1:0] phase_length();
    if ($urandom_range(4) == 0) return CFG_DAT_W'($urandom_range(0, 40));
    return CFG_DAT_W'($urandom_range(0, 6));
  endfunction

  // stop sending and let every expected result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (!drained);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // full register set, sometimes followed by a write to an unused index
  task automatic program_registers(input logic [CFG_DAT_W-1:0] weak_v, medium_v, strong_v,
                                   input logic [CFG_DAT_W-1:0] n_on_v, n_gap_v,
                                   input logic [CFG_DAT_W-1:0] a_on_v, a_off_v, pulse_v);
    set_register(REG_DUTY_WEAK, weak_v);
    set_register(REG_DUTY_MEDIUM, medium_v);
    set_register(REG_DUTY_STRONG, strong_v);
    set_register(REG_NOTIFY_ON, n_on_v);
    set_register(REG_NOTIFY_GAP, n_gap_v);
    set_register(REG_ALARM_ON, a_on_v);
    set_register(REG_ALARM_OFF, a_off_v);
    set_register(REG_PULSE_DEFAULT, pulse_v);
    if ($urandom_range(1) == 0)
      set_register(CFG_IDX_W'($urandom_range(REG_PULSE_DEFAULT + 1, 255)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // a command followed by a run of ticks, with stops and stray items mixed in
  task automatic run_sequence();
    int unsigned kind;
    int unsigned ticks;
    kind = $urandom_range(9);
    if (kind < 7) begin
      send_item(OP_CMD, 2'($urandom_range(PAT_PULSE, PAT_ALARM)), 2'($urandom),
                pulse_length());
      ticks = $urandom_range(0, 24);
    end else if (kind == 7) begin
      send_item(OP_CMD, PAT_STOP, 2'($urandom), 16'($urandom));
      ticks = $urandom_range(0, 4);
    end else begin
      send_item(1'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
      ticks = 0;
    end
    repeat (ticks) send_tick();
  endtask

  initial begin
    int unsigned phase_start;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: idle tick, strong pulse to its end, alarm cut by stop
    send_item(OP_TICK, PAT_STOP, STR_FOLDED, 16'hFFFF);
    send_item(OP_CMD, PAT_PULSE, STR_STRONG, 16'd2);
    send_tick();
    send_tick();
    send_tick();
    send_item(OP_CMD, PAT_ALARM, STR_FOLDED, 16'd0);
    send_item(OP_CMD, PAT_STOP, STR_WEAK, 16'd0);

    // short phases, alarm off time of zero, high duty bits dropped on write
    wait_drained();
    set_register(8'hFF, 16'h00AA);
    program_registers(16'd0, 16'hFFFF, 16'd512, 16'd2, 16'd1, 16'd1, 16'd0, 16'd3);

    // pulse with default length runs out
    send_item(OP_CMD, PAT_PULSE, STR_WEAK, 16'd0);
    repeat (3) send_tick();
    // notify through on, gap, on, then idle
    send_item(OP_CMD, PAT_NOTIFY, STR_STRONG, 16'd0);
    repeat (5) send_tick();
    // alarm wraps around its off phase
    send_item(OP_CMD, PAT_ALARM, STR_WEAK, 16'd0);
    repeat (3) send_tick();
    // longest pulse, replaced by notify, then stopped
    send_item(OP_CMD, PAT_PULSE, STR_MEDIUM, 16'hFFFF);
    send_item(OP_CMD, PAT_NOTIFY, STR_FOLDED, 16'd0);
    send_item(OP_CMD, PAT_STOP, STR_STRONG, 16'd5);

    // random phases, each with its own register setting; patterns left
    // running across the rewrite
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == 2)
        program_registers('1, '1, '1, '1, '1, '1, '1, '1);
      else if (p == 5)
        program_registers('0, '0, '0, '0, '0, '0, '0, '0);
      else
        program_registers(16'($urandom), 16'($urandom), 16'($urandom), phase_length(),
                          phase_length(), phase_length(), phase_length(), phase_length());
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_sequence();
    end

    wait_drained();
    // keep clocking to catch a stray extra result
    repeat (4) @(posedge clk);
    if (fail_count == 0 && drained) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
